// File: sv/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for quaternion to euler conversion
// Fixed formats, cordic lane record, arctangent table and rounding helpers.
// ----------------------------------------------------------------------------
package qte_pkg;

   // product terms are Q28 (2^28 = 1.0), held in 34 bits
   localparam int TERM_W = 34;
   // cordic datapath: vector words and angle accumulator (2^-15 degree units)
   localparam int CD_W   = 37;
   localparam int ANG_W  = 25;
   // square root: 29 result bits, 59 bit remainder
   localparam int ROOT_W = 29;
   localparam int REM_W  = 59;
   // arctangent table length; atan_entry defines entries 0 to 21, zero beyond
   localparam int ATAN_LEN = 24;

   typedef logic signed [TERM_W-1:0] term_type;
   typedef logic signed [CD_W-1:0]   cd_word_type;
   typedef logic signed [ANG_W-1:0]  cd_angle_type;
   typedef logic        [ROOT_W-1:0] root_type;
   typedef logic        [REM_W-1:0]  rem_type;
   typedef logic signed [17:0]       deg_type;

   localparam term_type     Q28_ONE = 34'sd268435456;
   localparam cd_angle_type DEG90   = 25'sd2949120;
   localparam cd_angle_type DEG180  = 25'sd5898240;
   localparam deg_type      LIM_180 = 18'sd23040;
   localparam deg_type      LIM_90  = 18'sd11520;

   // side terms carried alongside the square root
   typedef struct packed {
      term_type sinr;
      term_type cosr;
      term_type sinp;
      term_type siny;
      term_type cosy;
      logic     sat;
   } side_type;

   // one cordic lane: vector, angle and a fixed result that overrides it
   typedef struct packed {
      cd_word_type  x;
      cd_word_type  y;
      cd_angle_type z;
      logic         ovr;
      cd_angle_type zovr;
   } cd_lane_type;

   // atan(2^-i) in degrees times 32768, rounded
   function automatic cd_angle_type atan_entry(input logic [4:0] idx);
      cd_angle_type v;
      case (idx)
         5'd0:    v = 25'sd1474560;
         5'd1:    v = 25'sd870484;
         5'd2:    v = 25'sd459940;
         5'd3:    v = 25'sd233473;
         5'd4:    v = 25'sd117189;
         5'd5:    v = 25'sd58652;
         5'd6:    v = 25'sd29333;
         5'd7:    v = 25'sd14667;
         5'd8:    v = 25'sd7334;
         5'd9:    v = 25'sd3667;
         5'd10:   v = 25'sd1833;
         5'd11:   v = 25'sd917;
         5'd12:   v = 25'sd458;
         5'd13:   v = 25'sd229;
         5'd14:   v = 25'sd115;
         5'd15:   v = 25'sd57;
         5'd16:   v = 25'sd29;
         5'd17:   v = 25'sd14;
         5'd18:   v = 25'sd7;
         5'd19:   v = 25'sd4;
         5'd20:   v = 25'sd2;
         5'd21:   v = 25'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // quadrant fold of (y, x) into the right half plane, zero sine handled apart
   function automatic cd_lane_type cd_prep(input cd_word_type ys, input cd_word_type xs);
      cd_lane_type l;
      l.x    = xs;
      l.y    = ys;
      l.z    = '0;
      l.ovr  = (ys == '0);
      l.zovr = (xs < 0) ? DEG180 : '0;
      if (xs < 0) begin
         if (ys >= 0) begin
            l.x = ys;
            l.y = -xs;
            l.z = DEG90;
         end else begin
            l.x = -ys;
            l.y = xs;
            l.z = -DEG90;
         end
      end
      return l;
   endfunction

   // angle to 1/128 degree, nearest with ties away from zero, then clamp
   function automatic deg_type round_deg(input cd_angle_type z, input deg_type lim);
      logic [ANG_W-1:0] mag;
      logic [ANG_W:0]   sum;
      deg_type          r;
      mag = (z < 0) ? ANG_W'(-z) : ANG_W'(z);
      sum = {1'b0, mag} + (ANG_W+1)'(128);
      r   = deg_type'(sum[ANG_W:8]);
      if (r > lim) begin
         r = lim;
      end
      return (z < 0) ? -r : r;
   endfunction

endpackage

// File: sv/quaternion_to_euler_angles_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top: quaternion to roll, pitch and yaw
// Product terms, floor square root and three cordic vectoring lanes in one
// stall-able pipeline.
// ----------------------------------------------------------------------------
// One Q2.14 quaternion enters per clock and one set of ZYX euler angles
// (1/128 degree) leaves per clock. The stages run in order: input, products,
// sums, squaring, setup, the bit-per-stage square root that feeds the pitch
// cosine, the fold, the cordic micro-rotations and rounding. The whole pipeline
// holds while a result waits on rsp_tready; otherwise it takes a transaction
// every cycle.
module quaternion_to_euler_angles_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // quat_w, quat_x, quat_y, quat_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // roll_angle, pitch_angle, yaw_angle, pitch_saturated
);

   localparam int SQ_N = qte_pkg::ROOT_W;
   localparam int LAT  = 5 + SQ_N + 1 + CORDIC_STEPS + 1;

   logic           adv;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   // pipeline advances unless the result register is held
   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign vld_in     = {vld_ff[LAT-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // input register
   logic signed [15:0] qw_ff, qx_ff, qy_ff, qz_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         qw_ff <= req_tdata[15:0];
         qx_ff <= req_tdata[31:16];
         qy_ff <= req_tdata[47:32];
         qz_ff <= req_tdata[63:48];
      end
   end

   // products
   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         wx_ff <= qw_ff * qx_ff;
         yz_ff <= qy_ff * qz_ff;
         xx_ff <= qx_ff * qx_ff;
         yy_ff <= qy_ff * qy_ff;
         wy_ff <= qw_ff * qy_ff;
         zx_ff <= qz_ff * qx_ff;
         wz_ff <= qw_ff * qz_ff;
         xy_ff <= qx_ff * qy_ff;
         zz_ff <= qz_ff * qz_ff;
      end
   end

   // sine and cosine terms
   qte_pkg::side_type side2_in, side2_ff;

   always_comb begin
      side2_in.sinr = (qte_pkg::term_type'(wx_ff) + qte_pkg::term_type'(yz_ff)) <<< 1;
      side2_in.cosr = qte_pkg::Q28_ONE -
                      ((qte_pkg::term_type'(xx_ff) + qte_pkg::term_type'(yy_ff)) <<< 1);
      side2_in.sinp = (qte_pkg::term_type'(wy_ff) - qte_pkg::term_type'(zx_ff)) <<< 1;
      side2_in.siny = (qte_pkg::term_type'(wz_ff) + qte_pkg::term_type'(xy_ff)) <<< 1;
      side2_in.cosy = qte_pkg::Q28_ONE -
                      ((qte_pkg::term_type'(yy_ff) + qte_pkg::term_type'(zz_ff)) <<< 1);
      side2_in.sat  = (side2_in.sinp >= qte_pkg::Q28_ONE) ||
                      (side2_in.sinp <= -qte_pkg::Q28_ONE);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side2_ff <= side2_in;
      end
   end

   // square of the pitch sine
   logic [27:0]       sabs;
   logic [55:0]       sq_ff;
   qte_pkg::side_type side3_ff;

   always_comb begin
      sabs = (side2_ff.sinp < 0) ? 28'(-side2_ff.sinp) : 28'(side2_ff.sinp);
      if (side2_ff.sat) begin
         sabs = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff    <= sabs * sabs;
         side3_ff <= side2_ff;
      end
   end

   // square root pipeline, one result bit per stage
   qte_pkg::rem_type  sq_rem_ff  [0:SQ_N];
   qte_pkg::root_type sq_root_ff [0:SQ_N];
   qte_pkg::side_type sq_side_ff [0:SQ_N];

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_rem_ff[0]  <= (qte_pkg::REM_W'(1) << 56) - qte_pkg::REM_W'(sq_ff);
         sq_root_ff[0] <= '0;
         sq_side_ff[0] <= side3_ff;
      end
   end

   for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
      localparam int K = SQ_N - 1 - j;
      qte_pkg::rem_type  trial;
      qte_pkg::rem_type  rem_in;
      qte_pkg::root_type root_in;

      always_comb begin
         trial   = (qte_pkg::REM_W'(sq_root_ff[j]) << (K + 1)) |
                   (qte_pkg::REM_W'(1) << (2 * K));
         rem_in  = sq_rem_ff[j];
         root_in = sq_root_ff[j];
         if (sq_rem_ff[j] >= trial) begin
            rem_in  = sq_rem_ff[j] - trial;
            root_in = sq_root_ff[j] | (qte_pkg::ROOT_W'(1) << K);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[j+1]  <= rem_in;
            sq_root_ff[j+1] <= root_in;
            sq_side_ff[j+1] <= sq_side_ff[j];
         end
      end
   end

   // quadrant fold for the three lanes: roll, pitch, yaw
   qte_pkg::cd_lane_type cd_ff  [0:CORDIC_STEPS][0:2];
   logic                 sat_ff [0:CORDIC_STEPS];
   qte_pkg::cd_lane_type pl_in;
   qte_pkg::side_type    fs;

   always_comb begin
      fs    = sq_side_ff[SQ_N];
      pl_in = qte_pkg::cd_prep(qte_pkg::cd_word_type'(fs.sinp),
                 qte_pkg::cd_word_type'({1'b0, sq_root_ff[SQ_N]}));
      if (fs.sat) begin
         pl_in.ovr  = 1'b1;
         pl_in.zovr = (fs.sinp > 0) ? qte_pkg::DEG90 : -qte_pkg::DEG90;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cd_ff[0][0] <= qte_pkg::cd_prep(qte_pkg::cd_word_type'(fs.sinr),
                                         qte_pkg::cd_word_type'(fs.cosr));
         cd_ff[0][1] <= pl_in;
         cd_ff[0][2] <= qte_pkg::cd_prep(qte_pkg::cd_word_type'(fs.siny),
                                         qte_pkg::cd_word_type'(fs.cosy));
         sat_ff[0]   <= fs.sat;
      end
   end

   // cordic micro-rotations, one per stage
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      for (genvar l = 0; l < 3; l++) begin : g_lane
         qte_pkg::cd_lane_type c_in;
         qte_pkg::cd_word_type dx, dy;

         always_comb begin
            c_in = cd_ff[i][l];
            dx   = cd_ff[i][l].y >>> i;
            dy   = cd_ff[i][l].x >>> i;
            if (cd_ff[i][l].y > 0) begin
               c_in.x = cd_ff[i][l].x + dx;
               c_in.y = cd_ff[i][l].y - dy;
               c_in.z = cd_ff[i][l].z + qte_pkg::atan_entry(5'(i));
            end else begin
               c_in.x = cd_ff[i][l].x - dx;
               c_in.y = cd_ff[i][l].y + dy;
               c_in.z = cd_ff[i][l].z - qte_pkg::atan_entry(5'(i));
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               cd_ff[i+1][l] <= c_in;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sat_ff[i+1] <= sat_ff[i];
         end
      end
   end

   // rounding to 1/128 degree and result register
   qte_pkg::cd_angle_type za [0:2];
   qte_pkg::deg_type      roll_in, pitch_in, yaw_in;
   logic [15:0]           roll_ff, yaw_ff;
   logic [14:0]           pitch_ff;
   logic                  psat_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         za[l] = cd_ff[CORDIC_STEPS][l].ovr ? cd_ff[CORDIC_STEPS][l].zovr
                                            : cd_ff[CORDIC_STEPS][l].z;
      end
      roll_in  = qte_pkg::round_deg(za[0], qte_pkg::LIM_180);
      pitch_in = qte_pkg::round_deg(za[1], qte_pkg::LIM_90);
      yaw_in   = qte_pkg::round_deg(za[2], qte_pkg::LIM_180);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         roll_ff  <= roll_in[15:0];
         pitch_ff <= pitch_in[14:0];
         yaw_ff   <= yaw_in[15:0];
         psat_ff  <= sat_ff[CORDIC_STEPS];
      end
   end

   assign rsp_tdata = {psat_ff, yaw_ff, pitch_ff, roll_ff};

   // checks
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   a_hold_stable : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while the result was held");

   a_roll_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16'sd23040) &&
                     ($signed(rsp_tdata[15:0]) >= -16'sd23040))
      else $error("roll out of range");

   a_sat_pitch : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[47]) |->
         (rsp_tdata[30:16] == 15'd11520) || (rsp_tdata[30:16] == 15'd21248))
      else $error("saturated pitch is not at ninety degrees");

endmodule
